// File: src/sfr_pkg.sv
// sfr_pkg: shared constants and types for the sbus frame receiver
// no dependencies; imported by the frame receiver top level and its checker
`default_nettype none

package sfr_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES    = 25;
  localparam int unsigned NUM_CHANNELS   = 16;
  localparam int unsigned CHAN_BITS      = 11;
  localparam int unsigned FIRST_DATA_IDX = 1;
  localparam int unsigned LAST_DATA_IDX  = 22;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned ACC_W   = 18;
  localparam int unsigned OUT_TDATA_W = 16;

  // frame store: two banks so one frame can be unpacked while the next arrives
  localparam int unsigned STORE_BANKS = 2;
  localparam int unsigned STORE_DEPTH = STORE_BANKS * (1 << COUNT_W);

  // register reset values
  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h0F;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h00;

  // register indexes on the config port
  typedef enum logic {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } sfr_reg_t;

endpackage

`default_nettype wire

// File: src/sfr_ram.sv
// sfr_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/sbus_frame_receiver_top.sv
// sbus_frame_receiver_top: 25-byte frame collector and 16-channel 11-bit unpacker
// depends on sfr_pkg and sfr_ram
//
// input: one byte per cycle; tready drops only when a frame-closing byte arrives while the
//   previous frame is still being unpacked, so a good frame closes only once that is done
// output: after the closing byte, channel beats leave through the output register as 11 bits
//   gather from the registered store read, and hold while out_tready is low (a byte is
//   fetched only while fewer than 11 bits are on hand)
// reset: synchronous active low; clears framing and decoder control, the store is not cleared
`default_nettype none

module sbus_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] overrun

  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value, [15] zero
  output logic             out_tlast,  // last_channel

  // config port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  import sfr_pkg::*;

  // config registers
  logic [BYTE_W-1:0] start_marker_r;
  logic [BYTE_W-1:0] end_marker_r;
  sfr_reg_t          cfg_reg;
  logic              cfg_wr;

  // framing state
  logic               in_frame_r, in_frame_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               wr_bank_r;

  // decoder state
  logic               busy_r, busy_nxt;
  logic               rd_bank_r;
  logic               pend_r;
  logic [COUNT_W-1:0] rd_idx_r;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0] bits_r, bits_nxt;
  logic [INDEX_W-1:0] ch_r;

  // output register
  logic                  out_valid_r;
  logic [CHAN_BITS-1:0]  out_value_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic                  out_last_r;

  // input beat decode
  logic               in_fire;
  logic [BYTE_W-1:0]  rx_byte;
  logic               overrun;
  logic               cont;
  logic               opening;
  logic               closing;
  logic               good_frame;
  logic [COUNT_W-1:0] cnt_eff;
  logic [COUNT_W-1:0] cnt_inc;

  // decoder step
  logic               emit;
  logic               issue;
  logic [COUNT_W:0]   committed;
  logic [COUNT_W-1:0] bits_post;
  logic [ACC_W-1:0]   acc_post;
  logic [BYTE_W-1:0]  rd_data;

  // ---------------------------------------------------------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_reg    = sfr_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_START_MARKER: start_marker_r <= cfg_pwdata[BYTE_W-1:0];
        REG_END_MARKER:   end_marker_r   <= cfg_pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_START_MARKER: cfg_prdata = {{(32-BYTE_W){1'b0}}, start_marker_r};
      REG_END_MARKER:   cfg_prdata = {{(32-BYTE_W){1'b0}}, end_marker_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- framing
  // hold off a closing byte while the other bank is still being unpacked
  assign in_tready = !(busy_r && in_frame_r && (count_r == COUNT_W'(FRAME_BYTES - 1)));
  assign in_fire   = in_tvalid && in_tready;
  assign rx_byte   = in_tdata;
  assign overrun   = in_tuser[0];

  // an overrun drops the partial frame before the byte is looked at
  assign cont       = in_frame_r && !overrun;
  assign opening    = cont || (rx_byte == start_marker_r);
  assign cnt_eff    = cont ? count_r : '0;
  assign cnt_inc    = cnt_eff + COUNT_W'(1);
  assign closing    = opening && (cnt_inc == COUNT_W'(FRAME_BYTES));
  assign good_frame = in_fire && closing && (rx_byte == end_marker_r);

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    if (in_fire) begin
      if (opening && !closing) begin
        in_frame_nxt = 1'b1;
        count_nxt    = cnt_inc;
      end else begin
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      wr_bank_r  <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      // a good frame hands its bank to the decoder
      if (good_frame) begin
        wr_bank_r <= !wr_bank_r;
      end
    end
  end

  // ---------------------------------------------------------------- frame store
  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && opening),
    .waddr ({wr_bank_r, cnt_eff}),
    .wdata (rx_byte),
    .re    (issue),
    .raddr ({rd_bank_r, rd_idx_r}),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------- unpacker
  // bytes 1..22 are read in order into a bit accumulator, lsb first;
  // a channel leaves whenever 11 bits are on hand and the output slot is free
  assign emit = busy_r && (bits_r >= COUNT_W'(CHAN_BITS)) && (!out_valid_r || out_tready);

  assign bits_post = emit ? bits_r - COUNT_W'(CHAN_BITS) : bits_r;
  assign acc_post  = emit ? (acc_r >> CHAN_BITS) : acc_r;

  // bits held or on their way, after this cycle's channel leaves
  assign committed = {1'b0, bits_post} + (pend_r ? (COUNT_W+1)'(BYTE_W) : '0);
  assign issue     = busy_r && (rd_idx_r <= COUNT_W'(LAST_DATA_IDX))
                     && (committed < (COUNT_W+1)'(CHAN_BITS));

  always_comb begin
    acc_nxt  = acc_post;
    bits_nxt = bits_post;
    if (pend_r) begin
      acc_nxt  = acc_post | (ACC_W'(rd_data) << bits_post);
      bits_nxt = bits_post + COUNT_W'(BYTE_W);
    end
    busy_nxt = busy_r;
    if (emit && (ch_r == INDEX_W'(NUM_CHANNELS - 1))) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (good_frame) begin
      // accepted closing bytes only arrive while the decoder is idle
      busy_r <= 1'b1;
      pend_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (good_frame) begin
      rd_bank_r <= wr_bank_r;
      rd_idx_r  <= COUNT_W'(FIRST_DATA_IDX);
      bits_r    <= '0;
      acc_r     <= '0;
      ch_r      <= '0;
    end else begin
      acc_r  <= acc_nxt;
      bits_r <= bits_nxt;
      if (issue) begin
        rd_idx_r <= rd_idx_r + COUNT_W'(1);
      end
      if (emit) begin
        ch_r <= ch_r + INDEX_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= acc_r[CHAN_BITS-1:0];
      out_index_r <= ch_r;
      out_last_r  <= (ch_r == INDEX_W'(NUM_CHANNELS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CHAN_BITS - INDEX_W){1'b0}}, out_value_r, out_index_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: src/sfr_checker.sv
// sfr_checker: port-level assertions on the frame receiver result stream
// depends on sfr_pkg; bound to sbus_frame_receiver_top
`default_nettype none

module sfr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  import sfr_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // tlast marks exactly the last channel
  a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[INDEX_W-1:0] == INDEX_W'(NUM_CHANNELS - 1))))
    else $error("tlast does not match channel 15");

  // channels of a burst leave in order
  a_chan_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid
      |-> out_tdata[INDEX_W-1:0] == $past(out_tdata[INDEX_W-1:0]) + INDEX_W'(1))
    else $error("channel index out of sequence");

  // padding bit is zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[15])
    else $error("tdata padding bit set");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat out of reset");

endmodule

bind sbus_frame_receiver_top sfr_checker u_sfr_checker (.*);

`default_nettype wire
